### sv/epr_pkg.sv
// Shared constants, codes and table functions for the Euler point rotation core.
package epr_pkg;

   // CORDIC sine/cosine unit, Q2.30 on a 34-bit datapath
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_BITS  = 34;
   localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN_INV = 34'sh026DD3B6A;
   localparam logic signed [CORDIC_BITS-1:0] CORDIC_ONE      = 34'sh040000000;

   // register stages of the sine/cosine unit: load stage, one stage per step, output stage
   localparam int CORDIC_LATENCY = CORDIC_STEPS + 2;

   // rotation slots, each two register stages
   localparam int SLOT_COUNT  = 3;
   localparam int SLOT_STAGES = 2;

   // rotation mode codes
   localparam logic [2:0] MODE_ROT_X = 3'd0;
   localparam logic [2:0] MODE_ROT_Y = 3'd1;
   localparam logic [2:0] MODE_ROT_Z = 3'd2;
   localparam logic [2:0] MODE_XYZ   = 3'd3;
   localparam logic [2:0] MODE_ZYX   = 3'd4;

   // axis codes for one rotation slot
   localparam logic [1:0] AXIS_NONE = 2'd0;
   localparam logic [1:0] AXIS_X    = 2'd1;
   localparam logic [1:0] AXIS_Y    = 2'd2;
   localparam logic [1:0] AXIS_Z    = 2'd3;

   // arctangent of 2^-i as a 32-bit binary angle (2^31 = pi)
   function automatic logic [31:0] atan_entry(input int step);
      logic [31:0] val;
      unique case (step)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

   // axis turned in a given slot for a given mode
   function automatic logic [1:0] slot_axis(input logic [2:0] mode, input logic [1:0] slot);
      logic [1:0] ax;
      ax = AXIS_NONE;
      unique case (mode)
         MODE_ROT_X: ax = (slot == 2'd0) ? AXIS_X : AXIS_NONE;
         MODE_ROT_Y: ax = (slot == 2'd0) ? AXIS_Y : AXIS_NONE;
         MODE_ROT_Z: ax = (slot == 2'd0) ? AXIS_Z : AXIS_NONE;
         MODE_XYZ:   ax = (slot == 2'd0) ? AXIS_X : ((slot == 2'd1) ? AXIS_Y : AXIS_Z);
         MODE_ZYX:   ax = (slot == 2'd0) ? AXIS_Z : ((slot == 2'd1) ? AXIS_Y : AXIS_X);
         default:    ax = AXIS_NONE;
      endcase
      return ax;
   endfunction

endpackage

### sv/epr_cordic.sv
// Pipelined CORDIC sine/cosine unit, one step per register stage.
module epr_cordic #(
   parameter int ANGLE_WIDTH = 16,
   parameter int TRIG_WIDTH  = 30,
   parameter int TRIG_SHIFT  = 2
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [ANGLE_WIDTH-1:0]        angle,
   output logic signed [TRIG_WIDTH-1:0]  cos_out,
   output logic signed [TRIG_WIDTH-1:0]  sin_out
);
   import epr_pkg::*;

   localparam int N = CORDIC_STEPS;
   localparam int B = CORDIC_BITS;

   logic signed [B-1:0] x_ff [0:N];
   logic signed [B-1:0] y_ff [0:N];
   logic signed [B-1:0] z_ff [0:N];
   logic                flip_ff [0:N];

   logic [31:0] wide_angle;
   logic [31:0] turned_angle;
   logic        flip;

   // widen to a 32-bit binary angle, fold the back half-plane by pi
   assign wide_angle   = {angle, {(32-ANGLE_WIDTH){1'b0}}};
   assign flip         = wide_angle[31] ^ wide_angle[30];
   assign turned_angle = {wide_angle[31] ^ flip, wide_angle[30:0]};

   // load stage, then one micro-rotation per stage, arithmetic shifts
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= CORDIC_GAIN_INV;
         y_ff[0]    <= '0;
         z_ff[0]    <= {{(B-32){turned_angle[31]}}, turned_angle};
         flip_ff[0] <= flip;
         for (int i = 0; i < N; i++) begin
            if (!z_ff[i][B-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed({{(B-32){1'b0}}, atan_entry(i)});
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed({{(B-32){1'b0}}, atan_entry(i)});
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   // undo the fold, clamp to +-1.0, round to the trig precision
   logic signed [B-1:0] xn, yn, xc, yc, xr, yr;
   logic signed [TRIG_WIDTH-1:0] cos_ff, sin_ff;

   always_comb begin
      xn = flip_ff[N] ? -x_ff[N] : x_ff[N];
      yn = flip_ff[N] ? -y_ff[N] : y_ff[N];
      xc = (xn > CORDIC_ONE) ? CORDIC_ONE : ((xn < -CORDIC_ONE) ? -CORDIC_ONE : xn);
      yc = (yn > CORDIC_ONE) ? CORDIC_ONE : ((yn < -CORDIC_ONE) ? -CORDIC_ONE : yn);
   end

   if (TRIG_SHIFT == 0) begin : g_noround
      assign xr = xc;
      assign yr = yc;
   end else begin : g_round
      localparam logic signed [B-1:0] HALF = B'(1) <<< (TRIG_SHIFT - 1);
      assign xr = (xc + HALF) >>> TRIG_SHIFT;
      assign yr = (yc + HALF) >>> TRIG_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= xr[TRIG_WIDTH-1:0];
         sin_ff <= yr[TRIG_WIDTH-1:0];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

### sv/epr_rotate.sv
// One rotation slot: turns a coordinate pair by a sine/cosine pair in two stages.
module epr_rotate #(
   parameter int INNER_WIDTH = 35,
   parameter int TRIG_WIDTH  = 30,
   parameter int TRIG_FRAC   = 28
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [1:0]                   axis,
   input  logic [2:0][INNER_WIDTH-1:0]  pt_in,
   input  logic signed [TRIG_WIDTH-1:0] cos_in,
   input  logic signed [TRIG_WIDTH-1:0] sin_in,
   output logic [2:0][INNER_WIDTH-1:0]  pt_out
);
   import epr_pkg::*;

   localparam int PW = INNER_WIDTH + TRIG_WIDTH;
   localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (TRIG_FRAC - 1);

   logic signed [INNER_WIDTH-1:0] a, b;
   logic [2:0][INNER_WIDTH-1:0]   pt1_ff, pt2_ff;
   logic [1:0]                    axis1_ff;
   logic signed [PW-1:0]          ac_ff, bs_ff, as_ff, bc_ff;

   // pick the pair turned by this axis
   always_comb begin
      unique case (axis)
         AXIS_X:  begin a = $signed(pt_in[1]); b = $signed(pt_in[2]); end
         AXIS_Y:  begin a = $signed(pt_in[2]); b = $signed(pt_in[0]); end
         AXIS_Z:  begin a = $signed(pt_in[0]); b = $signed(pt_in[1]); end
         default: begin a = $signed(pt_in[0]); b = $signed(pt_in[1]); end
      endcase
   end

   // stage one: the four products
   always_ff @(posedge clock) begin
      if (enable) begin
         pt1_ff   <= pt_in;
         axis1_ff <= axis;
         ac_ff    <= PW'(a) * PW'(cos_in);
         bs_ff    <= PW'(b) * PW'(sin_in);
         as_ff    <= PW'(a) * PW'(sin_in);
         bc_ff    <= PW'(b) * PW'(cos_in);
      end
   end

   // stage two: sums, round half up, write the pair back
   logic signed [PW:0] da, db, ra, rb;
   logic [2:0][INNER_WIDTH-1:0] pt2_in;

   always_comb begin
      da = (PW+1)'(ac_ff) - (PW+1)'(bs_ff);
      db = (PW+1)'(as_ff) + (PW+1)'(bc_ff);
      ra = (da + HALF) >>> TRIG_FRAC;
      rb = (db + HALF) >>> TRIG_FRAC;
      pt2_in = pt1_ff;
      unique case (axis1_ff)
         AXIS_X:  begin pt2_in[1] = ra[INNER_WIDTH-1:0]; pt2_in[2] = rb[INNER_WIDTH-1:0]; end
         AXIS_Y:  begin pt2_in[2] = ra[INNER_WIDTH-1:0]; pt2_in[0] = rb[INNER_WIDTH-1:0]; end
         AXIS_Z:  begin pt2_in[0] = ra[INNER_WIDTH-1:0]; pt2_in[1] = rb[INNER_WIDTH-1:0]; end
         default: pt2_in = pt1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pt2_ff <= pt2_in;
      end
   end

   assign pt_out = pt2_ff;

endmodule

### sv/euler_point_rotation_3d_core.sv
// Euler point rotation core: pipelined CORDIC trig, three rotation slots, saturation.
//
// Rotates a 3D point about x, y or z alone, or about all three in x-y-z or z-y-x
// order, and returns the saturated result with a clip flag. One word is accepted
// per clock unless stalled; each word passes through 33 register stages (26 for the
// 24-step CORDIC pipeline that makes the three sine/cosine pairs in parallel, 2 for
// each of the three multiply-and-round rotation slots, 1 for saturation), the last
// of which is the output register that holds its result until it is taken. The
// pipeline stalls as a whole only while a finished result is held at the output
// and not taken. No state links words.
module euler_point_rotation_3d_core #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // point_x, point_y, point_z, angle_x, angle_y, angle_z
   input  logic [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic [2:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rotated_x, rotated_y, rotated_z
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic [0:0] rsp_tuser
);
   import epr_pkg::*;

   localparam int TRIG_FRAC   = ((60 - COORD_WIDTH) > 30) ? 30 : (60 - COORD_WIDTH);
   localparam int TRIG_WIDTH  = TRIG_FRAC + 2;
   localparam int TRIG_SHIFT  = 30 - TRIG_FRAC;
   localparam int INNER_WIDTH = COORD_WIDTH + 3;
   localparam int OUT_DW      = ((3*COORD_WIDTH+7)/8)*8;
   localparam int LAT         = CORDIC_LATENCY;
   localparam int SLOT_REGS   = SLOT_COUNT * SLOT_STAGES;
   localparam int LAST        = LAT + SLOT_REGS;

   // global advance: move when the output register is free or being taken
   logic en;
   logic v_ff [0:LAST];

   assign en         = !v_ff[LAST] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int k = 1; k <= LAST; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // unpack the input word
   logic [COORD_WIDTH-1:0] in_x, in_y, in_z;
   logic [ANGLE_WIDTH-1:0] in_ax, in_ay, in_az;

   assign in_x  = req_tdata[0*COORD_WIDTH +: COORD_WIDTH];
   assign in_y  = req_tdata[1*COORD_WIDTH +: COORD_WIDTH];
   assign in_z  = req_tdata[2*COORD_WIDTH +: COORD_WIDTH];
   assign in_ax = req_tdata[3*COORD_WIDTH + 0*ANGLE_WIDTH +: ANGLE_WIDTH];
   assign in_ay = req_tdata[3*COORD_WIDTH + 1*ANGLE_WIDTH +: ANGLE_WIDTH];
   assign in_az = req_tdata[3*COORD_WIDTH + 2*ANGLE_WIDTH +: ANGLE_WIDTH];

   // sine/cosine for all three angles in parallel
   logic signed [TRIG_WIDTH-1:0] cos_c [0:2];
   logic signed [TRIG_WIDTH-1:0] sin_c [0:2];
   logic [ANGLE_WIDTH-1:0]       ang [0:2];

   assign ang[0] = in_ax;
   assign ang[1] = in_ay;
   assign ang[2] = in_az;

   for (genvar g = 0; g < 3; g++) begin : g_trig
      epr_cordic #(
         .ANGLE_WIDTH (ANGLE_WIDTH),
         .TRIG_WIDTH  (TRIG_WIDTH),
         .TRIG_SHIFT  (TRIG_SHIFT)
      ) u_cordic (
         .clock   (clock),
         .enable  (en),
         .angle   (ang[g]),
         .cos_out (cos_c[g]),
         .sin_out (sin_c[g])
      );
   end

   // point and mode ride alongside the trig pipeline
   logic [2:0][INNER_WIDTH-1:0] point_d_ff [0:LAT-1];
   logic [2:0]                  mode_d_ff  [0:LAT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         point_d_ff[0] <= {INNER_WIDTH'($signed(in_z)), INNER_WIDTH'($signed(in_y)),
                           INNER_WIDTH'($signed(in_x))};
         mode_d_ff[0]  <= req_tuser;
         for (int k = 1; k < LAT; k++) begin
            point_d_ff[k] <= point_d_ff[k-1];
            mode_d_ff[k]  <= mode_d_ff[k-1];
         end
      end
   end

   // mode and trig delayed through the rotation slots
   logic [2:0]                    mode_ff [0:SLOT_REGS-1];
   logic [2:0][TRIG_WIDTH-1:0]    cosv_ff [0:SLOT_REGS-1];
   logic [2:0][TRIG_WIDTH-1:0]    sinv_ff [0:SLOT_REGS-1];
   logic [2:0]                    mode_at [0:SLOT_REGS];
   logic [2:0][TRIG_WIDTH-1:0]    cosv_at [0:SLOT_REGS];
   logic [2:0][TRIG_WIDTH-1:0]    sinv_at [0:SLOT_REGS];

   always_comb begin
      mode_at[0] = mode_d_ff[LAT-1];
      cosv_at[0] = {cos_c[2], cos_c[1], cos_c[0]};
      sinv_at[0] = {sin_c[2], sin_c[1], sin_c[0]};
      for (int k = 1; k <= SLOT_REGS; k++) begin
         mode_at[k] = mode_ff[k-1];
         cosv_at[k] = cosv_ff[k-1];
         sinv_at[k] = sinv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SLOT_REGS; k++) begin
            mode_ff[k] <= mode_at[k];
            cosv_ff[k] <= cosv_at[k];
            sinv_ff[k] <= sinv_at[k];
         end
      end
   end

   // three rotation slots in a chain
   logic [2:0][INNER_WIDTH-1:0] pt_at [0:SLOT_COUNT];

   assign pt_at[0] = point_d_ff[LAT-1];

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
      logic [1:0]                   axis;
      logic [1:0]                   sel;
      logic signed [TRIG_WIDTH-1:0] c_sel, s_sel;

      always_comb begin
         axis  = slot_axis(mode_at[s*SLOT_STAGES], 2'(s));
         sel   = (axis == AXIS_NONE) ? 2'd0 : (axis - 2'd1);
         c_sel = $signed(cosv_at[s*SLOT_STAGES][sel]);
         s_sel = $signed(sinv_at[s*SLOT_STAGES][sel]);
      end

      epr_rotate #(
         .INNER_WIDTH (INNER_WIDTH),
         .TRIG_WIDTH  (TRIG_WIDTH),
         .TRIG_FRAC   (TRIG_FRAC)
      ) u_rotate (
         .clock  (clock),
         .enable (en),
         .axis   (axis),
         .pt_in  (pt_at[s]),
         .cos_in (c_sel),
         .sin_in (s_sel),
         .pt_out (pt_at[s+1])
      );
   end

   // saturate to the coordinate range
   localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [2:0][COORD_WIDTH-1:0] sat_in;
   logic [2:0]                  clip;
   logic [2:0][COORD_WIDTH-1:0] sat_ff;
   logic                        flag_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [INNER_WIDTH-1:0] v;
         v       = pt_at[SLOT_COUNT][k];
         clip[k] = !((&v[INNER_WIDTH-1:COORD_WIDTH-1]) || !(|v[INNER_WIDTH-1:COORD_WIDTH-1]));
         if (clip[k]) sat_in[k] = v[INNER_WIDTH-1] ? C_MIN : C_MAX;
         else         sat_in[k] = v[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff  <= sat_in;
         flag_ff <= |clip;
      end
   end

   assign rsp_tdata    = OUT_DW'(sat_ff);
   assign rsp_tuser[0] = flag_ff;

   // a clip flag means some coordinate sits at a range limit
   a_flag_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && flag_ff |->
         (sat_ff[0] == C_MAX) || (sat_ff[0] == C_MIN) ||
         (sat_ff[1] == C_MAX) || (sat_ff[1] == C_MIN) ||
         (sat_ff[2] == C_MAX) || (sat_ff[2] == C_MIN))
      else $error("clip flag without a saturated coordinate");

   // an accepted word enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted word lost at pipeline entry");

   // a stall freezes the valid bits at entry, at the end of the trig pipeline and at the output
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> (v_ff[0] == $past(v_ff[0])) && (v_ff[LAT] == $past(v_ff[LAT])) &&
              (v_ff[LAST] == $past(v_ff[LAST])))
      else $error("pipeline moved during a stall");

endmodule
